/* sv/tafa_pkg.sv */
package tafa_pkg;

    localparam int NODE_COUNT = 256;
    // node fields are reduced to an index by truncation, so NODE_COUNT is a power of two
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FRAC_BITS  = 16;

    localparam int POS_W   = 32;
    localparam int FORCE_W = 48;
    localparam int EDGE_W  = POS_W + 1;

    // shared multiplier operands and product
    localparam int MA_W    = EDGE_W + 1;
    localparam int MB_W    = POS_W + 1;
    localparam int PROD_W  = MA_W + MB_W;

    // halved cross component, split in two for the scale multiply
    localparam int HALF_W  = 66 - FRAC_BITS;
    localparam int LO_W    = HALF_W / 2;
    localparam int HI_W    = HALF_W - LO_W;
    localparam int FULL_W  = HALF_W + MB_W;

    localparam int POS_MEM_W   = 3 * POS_W;
    localparam int FORCE_MEM_W = 3 * FORCE_W;

    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 152;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_APPLY = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage

/* sv/tafa_ram.sv */
module tafa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/triangle_area_force_assembly.sv */
// channel  dir  handshake          fields (low bit up)
// s_*      in   s_tvalid/s_tready  tdata node_a, node_b, node_c, value_x, value_y, value_z;
//                                  tuser operation; tlast last_element
// m_*      out  m_tvalid/m_tready  tdata node_index, force_x, force_y, force_z; tuser pass_done
// cfg_*    in   cfg_we             cfg_wdata area_force_scale
//
// load and clear are done at the accept, a read loads the output register in S_FOUT after S_FRD.
// an apply keeps the input busy from its accept through S_PRD (position reads), S_EDGE (edges),
// S_CALC (54 steps of the single shared multiplier, 6 per force component), then 3 force
// read-modify-writes in S_ARD and S_AWR; with last_element the result register is loaded at the end.
// forces reset to zero through per-node valid bits, no clearing pass.
// a pending output beat stalls the next result in S_FOUT, and the input is not ready while it waits.
module triangle_area_force_assembly
    import tafa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // node_a, node_b, node_c, value_x, value_y, value_z
    input  logic [1:0]          s_tuser,   // operation
    input  logic                s_tlast,   // last_element
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // node_index, force_x, force_y, force_z
    output logic                m_tuser,   // pass_done
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_PRD, S_EDGE, S_CALC, S_ARD, S_AWR, S_FRD, S_FOUT
    } state_t;

    state_t state_reg;
    logic [2:0] cnt_reg;
    logic [1:0] k_reg, j_reg;
    logic [2:0] ph_reg;
    logic done_reg, last_reg;
    logic out_valid_reg, out_done_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic signed [MB_W-1:0] neg_scale_reg;

    logic [NODE_W-1:0] node_reg [3];
    logic [7:0] index_reg;
    logic signed [POS_W-1:0] nrm_reg [3];
    logic signed [POS_W-1:0] pos_reg [3][3];
    logic signed [EDGE_W-1:0] edge_reg [3][3];
    logic signed [FORCE_W-1:0] inc_reg [3][3];
    logic signed [PROD_W-1:0] prod_reg, t1_reg, lo_prod_reg;
    logic signed [HALF_W-1:0] half_reg;

    logic [NODE_COUNT-1:0] valid_reg;
    logic rvalid_reg;

    logic accept;
    op_t in_op;
    logic [NODE_W-1:0] in_a;

    logic p_re;
    logic [NODE_W-1:0] p_raddr;
    logic [POS_MEM_W-1:0] p_rdata;

    logic f_we, f_re;
    logic [NODE_W-1:0] f_waddr, f_raddr;
    logic [FORCE_MEM_W-1:0] f_wdata, f_rdata, f_cur;

    logic [1:0] j1, j2;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p, cross_diff;
    logic signed [HI_W-1:0] half_hi;
    logic signed [FULL_W-1:0] full, full_sh;
    logic signed [FORCE_W-1:0] inc_next;
    logic inc_ovf;
    logic signed [FORCE_W-1:0] sum_sat [3];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);
    assign in_a     = NODE_W'(s_tdata[7:0]);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            neg_scale_reg <= -MB_W'($signed(cfg_wdata));
        end
    end

    // position memory, x in the low word
    assign p_re    = (state_reg == S_PRD) && (cnt_reg < 3'd3);
    always_comb
    begin
        case (cnt_reg)
            3'd0:    p_raddr = node_reg[0];
            3'd1:    p_raddr = node_reg[1];
            default: p_raddr = node_reg[2];
        endcase
    end

    tafa_ram #(.WIDTH(POS_MEM_W), .DEPTH(NODE_COUNT)) u_pos_ram (
        .clk   (clk),
        .we    (accept && in_op == OP_LOAD),
        .waddr (in_a),
        .wdata (s_tdata[S_DATA_W-1:24]),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // force memory with per-node valid bits standing in for the zero reset
    assign f_cur = rvalid_reg ? f_rdata : '0;

    always_comb
    begin
        logic signed [FORCE_W:0] s;
        for (int i = 0; i < 3; i++)
        begin
            s = (FORCE_W+1)'($signed(f_cur[i*FORCE_W +: FORCE_W]))
              + (FORCE_W+1)'(inc_reg[k_reg][i]);
            if (s[FORCE_W] != s[FORCE_W-1])
            begin
                sum_sat[i] = s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                        : {1'b0, {(FORCE_W-1){1'b1}}};
            end
            else
            begin
                sum_sat[i] = s[FORCE_W-1:0];
            end
        end
    end

    assign f_we    = (accept && in_op == OP_CLEAR) || (state_reg == S_AWR);
    assign f_waddr = (state_reg == S_AWR) ? node_reg[k_reg] : in_a;
    assign f_wdata = (state_reg == S_AWR) ? {sum_sat[2], sum_sat[1], sum_sat[0]} : '0;
    assign f_re    = (state_reg == S_ARD) || (state_reg == S_FRD);
    assign f_raddr = (state_reg == S_FRD) ? node_reg[0] : node_reg[k_reg];

    tafa_ram #(.WIDTH(FORCE_MEM_W), .DEPTH(NODE_COUNT)) u_force_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (f_we)
            begin
                valid_reg[f_waddr] <= 1'b1;
            end
            if (f_re)
            begin
                rvalid_reg <= valid_reg[f_raddr];
            end
        end
    end

    // cross component: x uses (dy,nz,dz,ny), y (dz,nx,dx,nz), z (dx,ny,dy,nx)
    always_comb
    begin
        case (j_reg)
            2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
            2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
            default: begin j1 = 2'd0; j2 = 2'd1; end
        endcase
    end

    assign half_hi = half_reg[HALF_W-1:LO_W];

    always_comb
    begin
        case (ph_reg)
            3'd1:
            begin
                mul_a = MA_W'(edge_reg[k_reg][j2]);
                mul_b = MB_W'(nrm_reg[j1]);
            end
            3'd3:
            begin
                mul_a = $signed({{(MA_W-LO_W){1'b0}}, half_reg[LO_W-1:0]});
                mul_b = neg_scale_reg;
            end
            3'd4:
            begin
                mul_a = MA_W'(half_hi);
                mul_b = neg_scale_reg;
            end
            default:
            begin
                mul_a = MA_W'(edge_reg[k_reg][j1]);
                mul_b = MB_W'(nrm_reg[j2]);
            end
        endcase
    end

    assign mul_p      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign cross_diff = t1_reg - (prod_reg >>> FRAC_BITS);
    assign full       = (FULL_W'(prod_reg) <<< LO_W) + FULL_W'(lo_prod_reg);
    assign full_sh    = full >>> FRAC_BITS;
    assign inc_ovf = !((&full_sh[FULL_W-1:FORCE_W-1]) || !(|full_sh[FULL_W-1:FORCE_W-1]));
    assign inc_next = inc_ovf ? (full_sh[FULL_W-1] ? {1'b1, {(FORCE_W-1){1'b0}}}
                                                   : {1'b0, {(FORCE_W-1){1'b1}}})
                              : full_sh[FORCE_W-1:0];

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg[0] <= in_a;
            node_reg[1] <= NODE_W'(s_tdata[15:8]);
            node_reg[2] <= NODE_W'(s_tdata[23:16]);
            index_reg   <= s_tdata[7:0];
            nrm_reg[0]  <= s_tdata[55:24];
            nrm_reg[1]  <= s_tdata[87:56];
            nrm_reg[2]  <= s_tdata[119:88];
        end
        if (state_reg == S_PRD && cnt_reg != 3'd0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[cnt_reg[1:0] - 2'd1][i] <= p_rdata[i*POS_W +: POS_W];
            end
        end
        if (state_reg == S_EDGE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                edge_reg[0][i] <= EDGE_W'(pos_reg[1][i]) - EDGE_W'(pos_reg[2][i]);
                edge_reg[1][i] <= EDGE_W'(pos_reg[2][i]) - EDGE_W'(pos_reg[0][i]);
                edge_reg[2][i] <= EDGE_W'(pos_reg[0][i]) - EDGE_W'(pos_reg[1][i]);
            end
        end
        if (state_reg == S_CALC)
        begin
            prod_reg <= mul_p;
            case (ph_reg)
                3'd1:    t1_reg      <= prod_reg >>> FRAC_BITS;
                3'd2:    half_reg    <= HALF_W'(cross_diff >>> 1);
                3'd4:    lo_prod_reg <= prod_reg;
                3'd5:    inc_reg[k_reg][j_reg] <= inc_next;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            ph_reg        <= '0;
            done_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= s_tlast;
                        cnt_reg  <= '0;
                        k_reg    <= '0;
                        j_reg    <= '0;
                        ph_reg   <= '0;
                        case (in_op)
                            OP_APPLY:
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= S_PRD;
                            end
                            OP_READ:
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= S_FRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PRD:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3)
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (ph_reg == 3'd5)
                    begin
                        ph_reg <= '0;
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            if (k_reg == 2'd2)
                            begin
                                k_reg     <= '0;
                                state_reg <= S_ARD;
                            end
                            else
                            begin
                                k_reg <= k_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_ARD:
                begin
                    state_reg <= S_AWR;
                end
                S_AWR:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= last_reg ? S_FRD : S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_ARD;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FOUT;
                end
                S_FOUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_done_reg  <= done_reg;
                        out_data_reg  <= {f_cur, index_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/tafa_checker.sv */
module tafa_checker
    import tafa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [1:0]          s_tuser,
    input logic                s_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                cfg_we,
    input logic [31:0]         cfg_wdata
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_LOAD || s_tuser == OP_CLEAR) |=> s_tready)
        else $error("load or clear left the block busy");

    a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_APPLY || s_tuser == OP_READ) |=> !s_tready)
        else $error("apply or read did not occupy the block");

    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

endmodule

bind triangle_area_force_assembly tafa_checker u_tafa_checker (.*);

/* sim/triangle_area_force_assembly_test.sv */
`timescale 1ns / 1ps

module triangle_area_force_assembly_test;
    import tafa_pkg::*;

    typedef struct {
        op_t               op;
        logic [7:0]        a;
        logic [7:0]        b;
        logic [7:0]        c;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic              last;
    } node_cmd_t;

    typedef struct {
        logic              done;
        logic [7:0]        idx;
        logic [47:0]       fx;
        logic [47:0]       fy;
        logic [47:0]       fz;
    } force_beat_t;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_we;
    logic [31:0]         cfg_wdata;

    node_cmd_t   cmd_queue[$];
    force_beat_t force_expected[$];

    // predictor state
    logic signed [31:0]  area_scale;
    logic signed [31:0]  pos_x[256];
    logic signed [31:0]  pos_y[256];
    logic signed [31:0]  pos_z[256];
    logic signed [47:0]  acc_x[256];
    logic signed [47:0]  acc_y[256];
    logic signed [47:0]  acc_z[256];

    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          beats_checked;
    int          elements_applied;
    int          hold_cnt;
    logic        hold_req;
    longint      cycles;
    logic [7:0]  loaded_nodes[$];
    bit          loaded[256];

    triangle_area_force_assembly DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [127:0] sat48(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF)
            return 128'sh7FFF_FFFF_FFFF;
        if (v < -128'sh8000_0000_0000)
            return -128'sh8000_0000_0000;
        return v;
    endfunction

    // floor((floor(d1*n2/2^F) - floor(d2*n1/2^F)) / 2)
    function automatic logic signed [127:0] half_cross(logic signed [127:0] d1,
        logic signed [127:0] n2, logic signed [127:0] d2, logic signed [127:0] n1);
        logic signed [127:0] c;
        c = ((d1 * n2) >>> FRAC_BITS) - ((d2 * n1) >>> FRAC_BITS);
        return c >>> 1;
    endfunction

    function automatic logic signed [127:0] scaled_inc(logic signed [127:0] h,
        logic signed [127:0] ns);
        return sat48((h * ns) >>> FRAC_BITS);
    endfunction

    function automatic void add_force(logic [7:0] n, logic signed [127:0] ix,
        logic signed [127:0] iy, logic signed [127:0] iz);
        acc_x[n] = 48'(sat48(128'(acc_x[n]) + ix));
        acc_y[n] = 48'(sat48(128'(acc_y[n]) + iy));
        acc_z[n] = 48'(sat48(128'(acc_z[n]) + iz));
    endfunction

    function automatic void push_force(logic done, logic [7:0] n);
        force_beat_t r;
        r.done = done;
        r.idx  = n;
        r.fx   = acc_x[n];
        r.fy   = acc_y[n];
        r.fz   = acc_z[n];
        force_expected.push_back(r);
    endfunction

    function automatic void predict_forces(node_cmd_t t);
        logic signed [127:0] ns, nx, ny, nz, dx, dy, dz;
        logic signed [127:0] inc[3][3];
        logic [7:0]          nd[3];
        logic [7:0]          p, q;
        nd[0] = t.a;
        nd[1] = t.b;
        nd[2] = t.c;
        case (t.op)
            OP_LOAD:
            begin
                pos_x[t.a] = t.x;
                pos_y[t.a] = t.y;
                pos_z[t.a] = t.z;
            end
            OP_APPLY:
            begin
                ns = -128'(area_scale);
                nx = 128'(t.x);
                ny = 128'(t.y);
                nz = 128'(t.z);
                // every increment is taken from positions before any update
                for (int k = 0; k < 3; k++)
                begin
                    p  = nd[(k + 1) % 3];
                    q  = nd[(k + 2) % 3];
                    dx = 128'(pos_x[p]) - 128'(pos_x[q]);
                    dy = 128'(pos_y[p]) - 128'(pos_y[q]);
                    dz = 128'(pos_z[p]) - 128'(pos_z[q]);
                    inc[k][0] = scaled_inc(half_cross(dy, nz, dz, ny), ns);
                    inc[k][1] = scaled_inc(half_cross(dz, nx, dx, nz), ns);
                    inc[k][2] = scaled_inc(half_cross(dx, ny, dy, nx), ns);
                end
                for (int k = 0; k < 3; k++)
                    add_force(nd[k], inc[k][0], inc[k][1], inc[k][2]);
                elements_applied++;
                if (t.last)
                    push_force(1'b1, t.a);
            end
            OP_READ:
                push_force(1'b0, t.a);
            default:
            begin
                acc_x[t.a] = '0;
                acc_y[t.a] = '0;
                acc_z[t.a] = '0;
            end
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        node_cmd_t t;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_LOAD;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                t = cmd_queue.pop_front();
                s_tdata  <= {t.z, t.y, t.x, t.c, t.b, t.a};
                s_tuser  <= t.op;
                s_tlast  <= t.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // predict at the accepting edge, in accept order
    always @(posedge clk)
    begin
        node_cmd_t t;
        if (rst_n && s_tvalid && s_tready)
        begin
            t.op   = op_t'(s_tuser);
            t.a    = s_tdata[7:0];
            t.b    = s_tdata[15:8];
            t.c    = s_tdata[23:16];
            t.x    = s_tdata[55:24];
            t.y    = s_tdata[87:56];
            t.z    = s_tdata[119:88];
            t.last = s_tlast;
            predict_forces(t);
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_req)
            hold_cnt <= 600;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        force_beat_t e;
        logic [47:0] ax, ay, az;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                beats_checked++;
                ax = m_tdata[55:8];
                ay = m_tdata[103:56];
                az = m_tdata[151:104];
                if (force_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: done %0b node %0d", m_tuser, m_tdata[7:0]);
                end
                else
                begin
                    e = force_expected.pop_front();
                    if (m_tuser !== e.done || m_tdata[7:0] !== e.idx || ax !== e.fx
                        || ay !== e.fy || az !== e.fz)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp done %0b node %0d f %h %h %h, got %0b %0d %h %h %h",
                                     e.done, e.idx, e.fx, e.fy, e.fz,
                                     m_tuser, m_tdata[7:0], ax, ay, az);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", force_expected.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value(bit small_only);
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return small_only ? 32'sh0001_0000 : 32'sh0;
            3, 4: return $signed(32'($urandom)) >>> $urandom_range(31, 8);
            default: return small_only ? $signed(32'($urandom)) >>> 12 : $signed(32'($urandom));
        endcase
    endfunction

    function automatic void add_cmd(op_t op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
        logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z, logic last);
        node_cmd_t t;
        t.op = op; t.a = a; t.b = b; t.c = c;
        t.x = x; t.y = y; t.z = z; t.last = last;
        if (op == OP_LOAD && !loaded[a])
        begin
            loaded[a] = 1'b1;
            loaded_nodes.push_back(a);
        end
        cmd_queue.push_back(t);
    endfunction

    function automatic logic [7:0] any_loaded();
        return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
    endfunction

    function automatic void random_cmd();
        int kind;
        kind = $urandom_range(99);
        if (kind < 25)
            add_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                    pick_value(0), pick_value(0), pick_value(0), 1'($urandom));
        else if (kind < 75)
            add_cmd(OP_APPLY, any_loaded(), any_loaded(), any_loaded(),
                    pick_value(1), pick_value(1), pick_value(1), $urandom_range(3) == 0);
        else if (kind < 90)
            add_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                    pick_value(0), pick_value(0), pick_value(0), 1'($urandom));
        else
            add_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                    pick_value(0), pick_value(0), pick_value(0), 1'($urandom));
    endfunction

    task automatic write_scale(logic [31:0] v);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        area_scale <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // drain, then let any result-less apply finish inside the block
    task automatic wait_drained();
        while (cmd_queue.size() > 0 || s_tvalid || force_expected.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] scales[6];
        int          send_pct[4];
        int          stall_pct[4];
        scales    = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'hFFFF_4000, 32'h0000_0001, 32'h0000_0000};
        send_pct  = '{0, 57, 0, 12};
        stall_pct = '{0, 0, 57, 12};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_req = 1'b0;
        area_scale = '0;
        cycles = 0;
        mismatches = 0;
        beats_checked = 0;
        elements_applied = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 256; i++)
        begin
            acc_x[i] = '0;
            acc_y[i] = '0;
            acc_z[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_scale(scales[0]);

        // directed: extreme positions and normals, repeated nodes, clear and read
        add_cmd(OP_READ, 8'd7, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        add_cmd(OP_LOAD, 8'd0, 8'hFF, 8'hFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        add_cmd(OP_LOAD, 8'd1, 8'd0, 8'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        add_cmd(OP_LOAD, 8'd2, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        add_cmd(OP_LOAD, 8'd255, 8'd0, 8'd0, 32'sh0003_0000, -32'sh0002_8000, 32'sh0000_0001, 1'b0);
        add_cmd(OP_APPLY, 8'd0, 8'd1, 8'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 1'b1);
        add_cmd(OP_APPLY, 8'd0, 8'd1, 8'd2, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        add_cmd(OP_APPLY, 8'd255, 8'd255, 8'd0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 1'b1);
        add_cmd(OP_APPLY, 8'd2, 8'd2, 8'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        add_cmd(OP_APPLY, 8'd1, 8'd255, 8'd2, 32'sh0000_8000, 0, -32'sh0000_8000, 1'b0);
        add_cmd(OP_READ, 8'd255, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        add_cmd(OP_READ, 8'd1, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        add_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        add_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        add_cmd(OP_APPLY, 8'd0, 8'd255, 8'd1, -32'sh0001_0000, 32'sh0000_4000, 0, 1'b1);
        add_cmd(OP_READ, 8'd2, 8'd0, 8'd0, 0, 0, 0, 1'b0);
        for (int i = 0; i < 24; i++)
            add_cmd(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                    pick_value(0), pick_value(0), pick_value(0), 1'b0);
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_scale(scales[ph + 1]);
            send_idle_pct  = send_pct[ph % 4];
            recv_stall_pct = stall_pct[ph % 4];
            if (ph == 1)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            for (int i = 0; i < 220; i++)
                random_cmd();
            wait_drained();
        end
        write_scale(scales[3]);

        if (force_expected.size() != 0)
            mismatches++;
        $display("%0d force beats checked, %0d elements applied over six scale settings",
                 beats_checked, elements_applied);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
sv/tafa_pkg.sv
sv/tafa_ram.sv
sv/triangle_area_force_assembly.sv
sv/tafa_checker.sv
sim/triangle_area_force_assembly_test.sv
